// File: hdl/canopy_layer_irradiance_fraction_defines.svh
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction: assertion macros
// Shared macros for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef CANOPY_LAYER_IRRADIANCE_FRACTION_DEFINES_SVH
`define CANOPY_LAYER_IRRADIANCE_FRACTION_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define CLIF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define CLIF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/clif_pkg.sv
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction: package
// Types, constants and the exponential factor table of the block.
// ---------------------------------------------------------------------------
package clif_pkg;

	localparam int STEP_W = 5;
	localparam int SQRT_STEPS = 16;
	localparam int EXP_STEPS = 20;
	localparam int EXP_BITS = 20;
	localparam int INC_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TRUNK_FRACTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_APPLY_ROOT = 1'b1;

	localparam logic [15:0] TRUNK_FRACTION_RST = 16'd6554;
	localparam logic [16:0] FACTOR_ONE = 17'h10000;
	localparam logic [31:0] ACC_ONE = 32'h8000_0000;
	localparam logic [30:0] SQRT_BIT_INIT = 31'h4000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRUNK,
		S_SQRT_INIT,
		S_SQRT,
		S_MUL1,
		S_MUL2,
		S_ACCUM,
		S_EXPL_INIT,
		S_EXPL,
		S_EXPL_DONE,
		S_EXPG_INIT,
		S_EXPG,
		S_EXPG_DONE,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TRUNK,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_MUL1,
		OP_MUL2,
		OP_ACCUM,
		OP_EXP_INIT,
		OP_EXP_STEP,
		OP_EXP_DONE,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic ground;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic last_in_layer;
		logic last_layer;
		logic sqrt_last;
		logic exp_last;
		logic out_busy;
	} status_t;

	function automatic logic [31:0] q31_sq(input logic [31:0] a);
		logic [63:0] p;
		logic [63:0] r;
		p = {32'd0, a} * {32'd0, a};
		r = (p + 64'h4000_0000) >> 31;
		return r[31:0];
	endfunction

	// exp(-2^(i-16)) in Q1.31.
	localparam logic [31:0] EXP_F15 = 32'd1302514674;
	localparam logic [31:0] EXP_F16 = q31_sq(EXP_F15);
	localparam logic [31:0] EXP_F17 = q31_sq(EXP_F16);
	localparam logic [31:0] EXP_F18 = q31_sq(EXP_F17);
	localparam logic [31:0] EXP_F19 = q31_sq(EXP_F18);

	function automatic logic [31:0] exp_factor(input logic [STEP_W-1:0] idx);
		logic [31:0] f;
		case (idx)
			5'd0: f = 32'd2147450880;
			5'd1: f = 32'd2147418113;
			5'd2: f = 32'd2147352580;
			5'd3: f = 32'd2147221520;
			5'd4: f = 32'd2146959424;
			5'd5: f = 32'd2146435328;
			5'd6: f = 32'd2145387520;
			5'd7: f = 32'd2143293437;
			5'd8: f = 32'd2139111403;
			5'd9: f = 32'd2130771798;
			5'd10: f = 32'd2114190000;
			5'd11: f = 32'd2081412522;
			5'd12: f = 32'd2017374191;
			5'd13: f = 32'd1895147668;
			5'd14: f = 32'd1672461947;
			5'd15: f = EXP_F15;
			5'd16: f = EXP_F16;
			5'd17: f = EXP_F17;
			5'd18: f = EXP_F18;
			5'd19: f = EXP_F19;
			default: f = ACC_ONE;
		endcase
		return f;
	endfunction

endpackage

// File: hdl/canopy_layer_irradiance_fraction.sv
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction
// Accumulates canopy optical depth element by element and gives the light
// fraction reaching each layer and the ground.
// ---------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         one canopy element (one cohort in one layer)
//  m_axis    out        one word per layer end
//  cfg       in         register writes, no read-back
//
// Each element runs the trunk step, the 16-step square root when enabled and
// multiplies into the depth sum; a layer end adds the 20-step exponential,
// a canopy end a second one for the ground. Only the exponential iterates on
// the shared multiplier. A finished word waits in the output register while
// the next element is taken in. Reset clears the depth state.
// ---------------------------------------------------------------------------
module canopy_layer_irradiance_fraction import clif_pkg::*; #(
	parameter int DEPTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// live_leaf_area, dead_leaf_area, max_leaf_area, extinction_coef, absorptance
	input  logic [79:0]          s_axis_tdata,
	input  logic                 s_axis_tlast,
	// last_layer
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// layer_fraction, ground_fraction
	output logic [31:0]          m_axis_tdata,
	// canopy_end
	output logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cmd_t cmd;
	status_t status;

	clif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	clif_dp #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.in_user   (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// File: hdl/clif_ctrl.sv
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction: controller
// Sequences the datapath through one canopy element at a time.
// ---------------------------------------------------------------------------
module clif_ctrl import clif_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.ground = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_TRUNK;
				end
			end
			S_TRUNK: begin
				cmd.op = OP_TRUNK;
				state_d = S_SQRT_INIT;
			end
			S_SQRT_INIT: begin
				cmd.op = OP_SQRT_INIT;
				state_d = status.mode ? S_SQRT : S_MUL1;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				if (status.sqrt_last) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.op = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op = OP_MUL2;
				state_d = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.op = OP_ACCUM;
				state_d = status.last_in_layer ? S_EXPL_INIT : S_IDLE;
			end
			S_EXPL_INIT: begin
				cmd.op = OP_EXP_INIT;
				state_d = S_EXPL;
			end
			S_EXPL: begin
				cmd.op = OP_EXP_STEP;
				if (status.exp_last) begin
					state_d = S_EXPL_DONE;
				end
			end
			S_EXPL_DONE: begin
				cmd.op = OP_EXP_DONE;
				state_d = status.last_layer ? S_EXPG_INIT : S_OUT;
			end
			S_EXPG_INIT: begin
				cmd.op = OP_EXP_INIT;
				cmd.ground = 1'b1;
				state_d = S_EXPG;
			end
			S_EXPG: begin
				cmd.op = OP_EXP_STEP;
				cmd.ground = 1'b1;
				if (status.exp_last) begin
					state_d = S_EXPG_DONE;
				end
			end
			S_EXPG_DONE: begin
				cmd.op = OP_EXP_DONE;
				cmd.ground = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!status.out_busy) begin
					cmd.op = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/clif_dp.sv
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction: datapath
// Shared multiplier, square root and exponential steps, depth accumulator,
// configuration registers and the output register.
// ---------------------------------------------------------------------------
module clif_dp import clif_pkg::*; #(
	parameter int DEPTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [79:0]          in_data,
	input  logic                 in_last,
	input  logic                 in_user,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_data,
	output logic                 out_last
);

	logic [15:0] live_q, dead_q, mx_q, k_q, alpha_q;
	logic lil_q, ll_q;
	logic [15:0] tf_q;
	logic mode_q;
	logic [DEPTH_BITS-1:0] depth_q, entry_q;
	logic opening_q;
	logic [16:0] area_q;
	logic [31:0] rem_q, res_q;
	logic [30:0] bit_q;
	logic [STEP_W-1:0] cnt_q;
	logic [32:0] prod_q;
	logic [INC_W-1:0] inc_q;
	logic [31:0] acc_q;
	logic [EXP_BITS-1:0] dsel_q;
	logic big_q;
	logic [15:0] layer_frac_q, ground_frac_q;
	logic out_valid_q;
	logic [31:0] out_data_q;
	logic out_last_q;

	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] mul_p;
	logic [16:0] sum_ld;
	logic [15:0] trunk;
	logic [31:0] sqrt_trial;
	logic sqrt_take;
	logic [16:0] factor;
	logic [DEPTH_BITS:0] depth_sum;
	logic [31:0] exp_round;
	logic [16:0] acc_r;
	logic [15:0] frac;
	logic [DEPTH_BITS-1:0] exp_src;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_TRUNK: begin
				mul_a = {17'd0, tf_q};
				mul_b = {16'd0, mx_q};
			end
			OP_MUL1: begin
				mul_a = {17'd0, k_q};
				mul_b = {15'd0, factor};
			end
			OP_MUL2: begin
				mul_a = prod_q;
				mul_b = {15'd0, area_q};
			end
			OP_EXP_STEP: begin
				mul_a = {1'b0, acc_q};
				mul_b = exp_factor(cnt_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};
	assign sum_ld = {1'b0, live_q} + {1'b0, dead_q};
	assign trunk = mul_p[31:16];
	assign sqrt_trial = res_q + {1'b0, bit_q};
	assign sqrt_take = (rem_q >= sqrt_trial);
	assign factor = mode_q ? {1'b0, res_q[15:0]} : FACTOR_ONE;
	assign depth_sum = {1'b0, depth_q} + {{(DEPTH_BITS + 1 - INC_W){1'b0}}, inc_q};
	assign exp_round = mul_p[62:31] + {31'd0, mul_p[30]};
	assign acc_r = acc_q[31:15] + {16'd0, acc_q[14]};
	assign frac = big_q ? 16'd0 : (acc_r[16] ? 16'hFFFF : acc_r[15:0]);
	assign exp_src = cmd.ground ? depth_q : entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q <= TRUNK_FRACTION_RST;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRUNK_FRACTION: tf_q <= cfg_data;
				REG_APPLY_ROOT: mode_q <= cfg_data[0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			entry_q <= '0;
			opening_q <= 1'b1;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (opening_q) begin
						entry_q <= depth_q;
						opening_q <= 1'b0;
					end
				end
				OP_ACCUM: begin
					depth_q <= depth_sum[DEPTH_BITS] ? '1 : depth_sum[DEPTH_BITS-1:0];
				end
				OP_OUT: begin
					opening_q <= 1'b1;
					if (ll_q) begin
						depth_q <= '0;
						entry_q <= '0;
					end
				end
				default: begin
					opening_q <= opening_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				live_q <= in_data[15:0];
				dead_q <= in_data[31:16];
				mx_q <= in_data[47:32];
				k_q <= in_data[63:48];
				alpha_q <= in_data[79:64];
				lil_q <= in_last;
				ll_q <= in_user;
			end
			OP_TRUNK: begin
				area_q <= (sum_ld > {1'b0, trunk}) ? sum_ld : {1'b0, trunk};
			end
			OP_SQRT_INIT: begin
				rem_q <= {alpha_q, 16'd0};
				res_q <= '0;
				bit_q <= SQRT_BIT_INIT;
				cnt_q <= '0;
			end
			OP_SQRT_STEP: begin
				if (sqrt_take) begin
					rem_q <= rem_q - sqrt_trial;
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
			end
			OP_MUL1: begin
				prod_q <= mul_p[32:0];
			end
			OP_MUL2: begin
				inc_q <= mul_p[49:26];
			end
			OP_EXP_INIT: begin
				dsel_q <= exp_src[EXP_BITS-1:0];
				big_q <= |exp_src[DEPTH_BITS-1:EXP_BITS];
				acc_q <= ACC_ONE;
				cnt_q <= '0;
			end
			OP_EXP_STEP: begin
				if (dsel_q[cnt_q]) begin
					acc_q <= exp_round;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			OP_EXP_DONE: begin
				if (cmd.ground) begin
					ground_frac_q <= frac;
				end else begin
					layer_frac_q <= frac;
				end
			end
			OP_OUT: begin
				out_data_q <= {(ll_q ? ground_frac_q : 16'd0), layer_frac_q};
				out_last_q <= ll_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign status.mode = mode_q;
	assign status.last_in_layer = lil_q;
	assign status.last_layer = ll_q;
	assign status.sqrt_last = (cnt_q == STEP_W'(SQRT_STEPS - 1));
	assign status.exp_last = (cnt_q == STEP_W'(EXP_STEPS - 1));
	assign status.out_busy = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

endmodule

// File: hdl/clif_checker.sv
// ---------------------------------------------------------------------------
// Canopy layer irradiance fraction: port checker
// Checks seen on the ports of the top level over time.
// ---------------------------------------------------------------------------
`include "canopy_layer_irradiance_fraction_defines.svh"

module clif_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	`CLIF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped")
	`CLIF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid, "output valid during reset")
	`CLIF_ASSERT(a_ground_zero, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:16] == 16'd0, "ground fraction set before canopy end")
	`CLIF_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second word taken while busy")

endmodule

bind canopy_layer_irradiance_fraction clif_checker u_clif_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
